>>> src/ptupt_pkg.sv
// Shared types and constants for the per-tag usage and peak tracker.
// No dependencies; imported by ptupt_update and per_tag_usage_peak_tracker.
package ptupt_pkg;

  localparam int TAG_COUNT_DEF = 256;
  localparam int TAG_IDX_W     = 8;
  localparam int CHANGE_W      = 48;
  localparam int AMOUNT_W      = 64;
  localparam int COUNT_W       = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED_TAG_INDEX = 1'd1;

  // One table entry as stored in the statistics memory.
  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic [AMOUNT_W-1:0] peak;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/ptupt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ptupt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ptupt_update.sv
// Entry update: applies one signed change to a tag's amount, count and peak.
// Depends on ptupt_pkg for entry_t and the field widths.
module ptupt_update (
  input  ptupt_pkg::entry_t                    old_entry,
  input  logic signed [ptupt_pkg::CHANGE_W-1:0] change,
  input  logic                                  apply,
  output ptupt_pkg::entry_t                    new_entry
);
  import ptupt_pkg::*;

  logic [AMOUNT_W-1:0] delta_ext;
  logic [AMOUNT_W-1:0] sum;
  logic                is_alloc;

  assign delta_ext = {{(AMOUNT_W - CHANGE_W){change[CHANGE_W-1]}}, change};
  assign sum       = old_entry.amount + delta_ext;
  assign is_alloc  = (change != '0) && !change[CHANGE_W-1];

  always_comb begin
    new_entry = old_entry;
    if (apply) begin
      new_entry.amount = sum;
      if (is_alloc) begin
        if (old_entry.count != {COUNT_W{1'b1}}) begin
          new_entry.count = old_entry.count + COUNT_W'(1);
        end
        if ($signed(sum) > $signed(old_entry.peak)) begin
          new_entry.peak = sum;
        end
      end
    end
  end

endmodule

>>> src/per_tag_usage_peak_tracker.sv
// Per-tag memory usage tracker: keeps amount, peak and allocation count per tag.
// Depends on ptupt_pkg, ptupt_ram and ptupt_update.
//
// Usage:
//   Input beats (in_valid / in_stall) carry a tag, a signed 48-bit change and a
//   clear flag. Every input beat produces exactly one output beat on out_valid /
//   out_stall with the tag's amount, peak and count after the change, plus
//   was_applied. One beat is accepted per cycle while in_stall is low; the
//   statistics memory is read at the accepting edge, and the update is computed
//   and registered into the output when the update stage advances.
//   The rate is set by the read-modify-write of the single statistics memory;
//   a write is forwarded to the item right behind it, so back-to-back beats on
//   the same tag need no bubble.
//   The user must write configuration (cfg_we, cfg_index, cfg_wdata) only while idle; the block does not enforce it.
//   Reset sets tracking enabled, paused tag 1, and marks every entry as zero
//   through per-entry valid flags, so no clearing pass is needed; the clear flag
//   uses the same flags and also takes effect at once.
//   When the receiver stalls, the output register holds its beat, the update
//   stage holds one more item, and in_stall rises once both are occupied.
module per_tag_usage_peak_tracker #(
  parameter int TAG_COUNT = ptupt_pkg::TAG_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ptupt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptupt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ptupt_pkg::TAG_IDX_W-1:0]       in_tag_index,
  input  logic signed [ptupt_pkg::CHANGE_W-1:0] in_change_amount,
  input  logic                                  in_clear_all,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ptupt_pkg::AMOUNT_W-1:0] out_current_amount,
  output logic signed [ptupt_pkg::AMOUNT_W-1:0] out_peak_amount,
  output logic [ptupt_pkg::COUNT_W-1:0]         out_allocation_count,
  output logic                                  out_was_applied
);
  import ptupt_pkg::*;

  localparam int TAG_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

  // Configuration registers.
  logic                 track_en_r;
  logic [TAG_IDX_W-1:0] paused_tag_r;

  // Update stage holding one accepted item while its entry is read.
  logic                        s1_valid_r;
  logic [TAG_IDX_W-1:0]        s1_tag_r;
  logic signed [CHANGE_W-1:0]  s1_change_r;
  logic                        s1_clear_r;

  // Last write, forwarded to the item whose read overlapped it.
  logic             wb_valid_r;
  logic [TAG_W-1:0] wb_idx_r;
  entry_t           wb_data_r;

  logic entry_valid_r [TAG_COUNT];

  logic             out_valid_r;
  entry_t           out_entry_r;
  logic             out_applied_r;

  logic             in_accept;
  logic             s1_adv;
  logic [TAG_W-1:0] s1_idx;
  logic             s1_in_range;
  logic             s1_applied;
  logic             fwd_hit;
  entry_t           ram_rdata;
  entry_t           old_entry;
  entry_t           new_entry;
  entry_t           result_entry;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign s1_idx      = s1_tag_r[TAG_W-1:0];
  assign s1_in_range = {1'b0, s1_tag_r} < (TAG_IDX_W + 1)'(TAG_COUNT);
  assign s1_applied  = s1_in_range && track_en_r && (s1_tag_r != paused_tag_r);
  assign fwd_hit     = wb_valid_r && (wb_idx_r == s1_idx);

  ptupt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TAG_COUNT)
  ) u_stats_ram (
    .clk   (clk),
    .we    (s1_adv && s1_applied),
    .waddr (s1_idx),
    .wdata (new_entry),
    .re    (in_accept),
    .raddr (in_tag_index[TAG_W-1:0]),
    .rdata (ram_rdata)
  );

  // A clear on this item wins over everything; then the overlapping write;
  // then the memory, for entries written since the last clear.
  always_comb begin
    if (s1_clear_r) begin
      old_entry = '0;
    end else if (fwd_hit) begin
      old_entry = wb_data_r;
    end else if (entry_valid_r[s1_idx]) begin
      old_entry = ram_rdata;
    end else begin
      old_entry = '0;
    end
  end

  ptupt_update u_update (
    .old_entry (old_entry),
    .change    (s1_change_r),
    .apply     (s1_applied),
    .new_entry (new_entry)
  );

  assign result_entry = s1_in_range ? new_entry : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r   <= 1'b1;
      paused_tag_r <= TAG_IDX_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRACKING_ENABLED: track_en_r   <= cfg_wdata[0];
        REG_PAUSED_TAG_INDEX: paused_tag_r <= cfg_wdata[TAG_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tag_r    <= in_tag_index;
      s1_change_r <= in_change_amount;
      s1_clear_r  <= in_clear_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (s1_adv) begin
      wb_valid_r <= s1_applied;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wb_idx_r  <= s1_idx;
      wb_data_r <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAG_COUNT; i++) begin
      if (!rst_n) begin
        entry_valid_r[i] <= 1'b0;
      end else if (s1_adv) begin
        if (s1_applied && (s1_idx == TAG_W'(i))) begin
          entry_valid_r[i] <= 1'b1;
        end else if (s1_clear_r) begin
          entry_valid_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_entry_r   <= result_entry;
      out_applied_r <= s1_applied;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_current_amount   = $signed(out_entry_r.amount);
  assign out_peak_amount      = $signed(out_entry_r.peak);
  assign out_allocation_count = out_entry_r.count;
  assign out_was_applied      = out_applied_r;

endmodule
